// File: hdl/secs_pkg.sv
// ----------------------------------------------------------------------------
// secs_pkg
// Shared widths, reset values and helpers for the seam energy cost stream.
// ----------------------------------------------------------------------------
package secs_pkg;

  localparam int PixelBits     = 16;
  localparam int EnergyBits    = 18;
  localparam int CostBits      = 32;
  localparam int RowLenBits    = 11;
  localparam int MaxColsReset  = 1024;

  localparam int InDataBits    = 16;
  localparam int OutDataBits   = 56;
  localparam int OutPadBits    = OutDataBits - EnergyBits - CostBits;

  localparam logic [RowLenBits-1:0] RowLenReset = RowLenBits'(1024);
  localparam logic [CostBits-1:0]   CostMax     = {CostBits{1'b1}};
  // Three neighbor differences of full-scale pixels.
  localparam logic [EnergyBits-1:0] EnergyPeak  =
    EnergyBits'(3 * ((2 ** PixelBits) - 1));

  function automatic logic [PixelBits-1:0] abs_diff(input logic [PixelBits-1:0] a,
                                                    input logic [PixelBits-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: hdl/seam_energy_cost_stream.sv
// ----------------------------------------------------------------------------
// seam_energy_cost_stream
// Per-pixel energy and cumulative minimum seam cost over a streamed image.
// ----------------------------------------------------------------------------
// Each pixel is registered in stage 1, then its result in the output register.
// Throughput: one pixel per cycle unless the output stalls, set by the
// read-modify-write of the lower-row line stores (cost: two read ports, one write).
// Reset: control, row length (1024) and neighbor registers are cleared at once;
// the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module seam_energy_cost_stream #(
  parameter int MaxCols = secs_pkg::MaxColsReset
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: row length in pixels.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [secs_pkg::RowLenBits-1:0]    cfg_data_i,
  // Pixel stream in.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [secs_pkg::InDataBits-1:0]    s_axis_tdata,  // [15:0] pixel
  input  logic                               s_axis_tuser,  // [0] frame_start
  // Result stream out.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [secs_pkg::OutDataBits-1:0]   m_axis_tdata,  // [17:0] energy,
                                                            // [49:18] path_cost
  output logic                               m_axis_tlast   // row_end
);

  localparam int ColW = $clog2(MaxCols);
  localparam int CmpW = (ColW + 1 > secs_pkg::RowLenBits) ? ColW + 1 : secs_pkg::RowLenBits;
  localparam int PixW = secs_pkg::PixelBits;
  localparam int EnW  = secs_pkg::EnergyBits;
  localparam int CoW  = secs_pkg::CostBits;

  // Line stores of the row below, indexed by position from the right end.
  logic [PixW-1:0] pix_mem  [MaxCols];
  logic [CoW-1:0]  cost_mem [MaxCols];

  logic [secs_pkg::RowLenBits-1:0] row_len_q;
  logic [ColW-1:0] col_q, col_d;
  logic            bottom_q, bottom_d;
  logic [PixW-1:0] right_pix_q;
  logic [PixW-1:0] held_pix_q;
  logic [CoW-1:0]  held_cost_q;

  // Stage 1: pixel waiting on its line store reads.
  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q, s1_right_q;
  logic [ColW-1:0] s1_pos_q;
  logic            s1_bottom_q, s1_pos_nz_q, s1_has_right_q, s1_row_done_q;

  logic [PixW-1:0] rd_pix_q;
  logic [CoW-1:0]  rd_lo_cost_q, rd_hi_cost_q;
  logic            fwd_lo_q, fwd_hi_q;
  logic [PixW-1:0] fwd_pix_q;
  logic [CoW-1:0]  fwd_cost_q;

  // Output register.
  logic            out_valid_q;
  logic [EnW-1:0]  out_energy_q;
  logic [CoW-1:0]  out_cost_q;
  logic            out_last_q;

  logic            in_acc, s1_adv;
  logic [PixW-1:0] in_pix;
  logic [CmpW-1:0] len_raw, len_eff, pos_ext, pos_inc;
  logic [ColW-1:0] pos, rd_lo, rd_hi;
  logic            bottom, row_done;

  logic [PixW-1:0] low_pix;
  logic [CoW-1:0]  low_cost, hi_cost, min_cost;
  logic [PixW-1:0] d_right, d_low, d_low_right;
  logic [EnW-1:0]  energy;
  logic [CoW:0]    cost_sum;
  logic [CoW-1:0]  cost;

  // --------------------------------------------------------------------------
  // Handshakes and column tracking
  // --------------------------------------------------------------------------
  assign cfg_ready_o   = 1'b1;
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_pix        = s_axis_tdata[PixW-1:0];

  always_comb begin
    len_raw = CmpW'(row_len_q);
    if (len_raw == '0) begin
      len_eff = CmpW'(1);
    end else if (len_raw > CmpW'(MaxCols)) begin
      len_eff = CmpW'(MaxCols);
    end else begin
      len_eff = len_raw;
    end
    pos      = s_axis_tuser ? '0 : col_q;
    bottom   = s_axis_tuser ? 1'b1 : bottom_q;
    pos_ext  = CmpW'(pos);
    pos_inc  = pos_ext + CmpW'(1);
    row_done = (pos_inc >= len_eff);
    col_d    = row_done ? '0 : pos_inc[ColW-1:0];
    bottom_d = row_done ? 1'b0 : bottom;
    rd_lo    = pos;
    rd_hi    = row_done ? '0 : pos_inc[ColW-1:0];
  end

  // --------------------------------------------------------------------------
  // Line stores: read at transfer, written back when the pixel leaves stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pix_mem[s1_pos_q]  <= s1_pix_q;
      cost_mem[s1_pos_q] <= cost;
    end
    if (in_acc) begin
      rd_pix_q     <= pix_mem[rd_lo];
      rd_lo_cost_q <= cost_mem[rd_lo];
      rd_hi_cost_q <= cost_mem[rd_hi];
      // A write in the same cycle is missed by the read; bypass it.
      fwd_lo_q     <= s1_adv && (s1_pos_q == rd_lo);
      fwd_hi_q     <= s1_adv && (s1_pos_q == rd_hi);
      fwd_pix_q    <= s1_pix_q;
      fwd_cost_q   <= cost;
    end
  end

  // --------------------------------------------------------------------------
  // Energy and cost
  // --------------------------------------------------------------------------
  always_comb begin
    low_pix  = fwd_lo_q ? fwd_pix_q  : rd_pix_q;
    low_cost = fwd_lo_q ? fwd_cost_q : rd_lo_cost_q;
    hi_cost  = fwd_hi_q ? fwd_cost_q : rd_hi_cost_q;

    d_right     = s1_pos_nz_q ? secs_pkg::abs_diff(s1_pix_q, s1_right_q) : '0;
    d_low       = !s1_bottom_q ? secs_pkg::abs_diff(s1_pix_q, low_pix) : '0;
    d_low_right = (!s1_bottom_q && s1_pos_nz_q) ?
                  secs_pkg::abs_diff(s1_pix_q, held_pix_q) : '0;
    energy      = EnW'(d_right) + EnW'(d_low) + EnW'(d_low_right);

    min_cost = low_cost;
    if (s1_pos_nz_q && (held_cost_q < min_cost)) begin
      min_cost = held_cost_q;
    end
    if (s1_has_right_q && (hi_cost < min_cost)) begin
      min_cost = hi_cost;
    end
    cost_sum = {1'b0, min_cost} + (CoW + 1)'(energy);
    if (s1_bottom_q) begin
      cost = CoW'(energy);
    end else if (cost_sum[CoW]) begin
      cost = secs_pkg::CostMax;
    end else begin
      cost = cost_sum[CoW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q   <= secs_pkg::RowLenReset;
      col_q       <= '0;
      bottom_q    <= 1'b1;
      right_pix_q <= '0;
      held_pix_q  <= '0;
      held_cost_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        row_len_q <= cfg_data_i;
      end
      if (in_acc) begin
        col_q       <= col_d;
        bottom_q    <= bottom_d;
        right_pix_q <= in_pix;
      end
      if (s1_adv) begin
        held_pix_q  <= low_pix;
        held_cost_q <= low_cost;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q       <= in_pix;
      s1_right_q     <= right_pix_q;
      s1_pos_q       <= pos;
      s1_bottom_q    <= bottom;
      s1_pos_nz_q    <= (pos != '0);
      s1_has_right_q <= !row_done;
      s1_row_done_q  <= row_done;
    end
    if (s1_adv) begin
      out_energy_q <= energy;
      out_cost_q   <= cost;
      out_last_q   <= s1_row_done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{secs_pkg::OutPadBits{1'b0}}, out_cost_q, out_energy_q};
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(col_q) < CmpW'(MaxCols))
    else $error("column count beyond line store depth");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && row_done |=> (col_q == '0) && !bottom_q)
    else $error("row end did not restart the column count");

  a_energy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_energy_q <= secs_pkg::EnergyPeak))
    else $error("energy above three full-scale differences");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_pos_q) && $stable(s1_pix_q))
    else $error("stage 1 pixel lost while stalled");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seam energy cost stream. Pixel runs and row
// length settings are generated so that no row reads line store entries that
// were never written. Every accepted pixel goes through a local predictor of
// energy and cumulative seam cost, and every result transfer is checked
// against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          PixelBits   = secs_pkg::PixelBits;
  localparam int          EnergyBits  = secs_pkg::EnergyBits;
  localparam int          CostBits    = secs_pkg::CostBits;
  localparam int          RowLenBits  = secs_pkg::RowLenBits;
  localparam int          InDataBits  = secs_pkg::InDataBits;
  localparam int          OutDataBits = secs_pkg::OutDataBits;
  localparam logic [RowLenBits-1:0] RowLenReset = secs_pkg::RowLenReset;
  localparam logic [CostBits-1:0]   CostMax     = secs_pkg::CostMax;

  localparam int          MAX_COLS   = secs_pkg::MaxColsReset;
  localparam int unsigned ENERGY_SAT = 262143;
  localparam longint      COST_SAT   = 64'd4294967295;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          PRINT_CAP  = 100;
  localparam int          LONG_HOLD  = 400;

  typedef struct packed {
    logic [PixelBits-1:0] pixel;
    logic                 frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [EnergyBits-1:0] energy;
    logic [CostBits-1:0]   path_cost;
    logic                  row_end;
  } seam_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [RowLenBits-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  seam_energy_cost_stream u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pixel_item_t  pixel_q[$];
  seam_result_t expected_costs[$];

  int  error_count  = 0;
  int  cycle_count  = 0;
  int  pixels_taken = 0;
  int  rows_closed  = 0;
  int  settings     = 0;
  bit  idle_on      = 1'b1;
  bit  in_taken     = 1'b0;
  int  tx_gap       = 0;
  int  rx_gap       = 0;
  int  hold_requests = 0;
  int  hold_served  = 0;
  int  hold_left    = 0;

  // Predictor state.
  logic [RowLenBits-1:0] prd_row_len = RowLenReset;
  logic [PixelBits-1:0]  lower_pix  [MAX_COLS];
  logic [CostBits-1:0]   lower_cost [MAX_COLS];
  logic [PixelBits-1:0]  prd_right     = '0;
  logic [PixelBits-1:0]  prd_held_pix  = '0;
  logic [CostBits-1:0]   prd_held_cost = '0;
  int unsigned           prd_col       = 0;
  bit                    prd_bottom    = 1'b1;

  // Stimulus-side tracking of which line entries hold data.
  int unsigned gen_len    = MAX_COLS;
  int unsigned gen_col    = 0;
  bit          gen_bottom = 1'b1;
  bit          gen_written [MAX_COLS];

  initial begin
    for (int i = 0; i < MAX_COLS; i++) begin
      lower_pix[i]   = '0;
      lower_cost[i]  = '0;
      gen_written[i] = 1'b0;
    end
  end

  function automatic int unsigned pixel_gap(input logic [PixelBits-1:0] a,
                                            input logic [PixelBits-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic int unsigned clamp_len(input logic [RowLenBits-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_COLS) return MAX_COLS;
    return value;
  endfunction

  task automatic compute_seam_cost(input pixel_item_t item);
    int unsigned    len;
    int unsigned    pos;
    int unsigned    e;
    longint         sum;
    logic [CostBits-1:0]  m;
    logic [CostBits-1:0]  cost;
    logic [PixelBits-1:0] lp;
    logic [CostBits-1:0]  lc;
    seam_result_t   res;
    len = clamp_len(prd_row_len);
    if (item.frame_start) begin
      prd_col    = 0;
      prd_bottom = 1'b1;
    end
    pos = prd_col % MAX_COLS;
    lp  = lower_pix[pos];
    lc  = lower_cost[pos];
    e   = 0;
    if (pos > 0) e += pixel_gap(item.pixel, prd_right);
    if (!prd_bottom) begin
      e += pixel_gap(item.pixel, lp);
      if (pos > 0) e += pixel_gap(item.pixel, prd_held_pix);
    end
    if (e > ENERGY_SAT) e = ENERGY_SAT;
    if (prd_bottom) begin
      cost = e;
    end else begin
      m = lc;
      if (pos > 0 && prd_held_cost < m) m = prd_held_cost;
      if (pos + 1 < len && pos + 1 < MAX_COLS && lower_cost[pos + 1] < m) begin
        m = lower_cost[pos + 1];
      end
      sum  = longint'(e) + longint'(m);
      cost = (sum > COST_SAT) ? CostMax : sum[CostBits-1:0];
    end
    prd_held_pix    = lp;
    prd_held_cost   = lc;
    lower_pix[pos]  = item.pixel;
    lower_cost[pos] = cost;
    prd_right       = item.pixel;
    res.energy    = e[EnergyBits-1:0];
    res.path_cost = cost;
    res.row_end   = (pos + 1 >= len);
    if (res.row_end) begin
      prd_col    = 0;
      prd_bottom = 1'b0;
    end else begin
      prd_col = pos + 1;
    end
    expected_costs.push_back(res);
  endtask

  // A row above the bottom one may only read columns the row below has written.
  function automatic bit restart_needed();
    int unsigned pos;
    pos = gen_col;
    if (gen_bottom) return 1'b0;
    if (!gen_written[pos]) return 1'b1;
    if (pos + 1 < gen_len && pos + 1 < MAX_COLS && !gen_written[pos + 1]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic queue_pixel(input logic [PixelBits-1:0] pixel, input bit fs);
    pixel_item_t item;
    int unsigned pos;
    if (!fs && restart_needed()) fs = 1'b1;
    if (fs) begin
      gen_col    = 0;
      gen_bottom = 1'b1;
    end
    pos = gen_col;
    gen_written[pos] = 1'b1;
    if (pos + 1 >= gen_len) begin
      gen_col    = 0;
      gen_bottom = 1'b0;
    end else begin
      gen_col = pos + 1;
    end
    item.pixel       = pixel;
    item.frame_start = fs;
    pixel_q.push_back(item);
  endtask

  function automatic logic [PixelBits-1:0] pick_pixel(input logic [PixelBits-1:0] prev);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return prev + PixelBits'($urandom_range(0, 31)) - PixelBits'(16);
      default: return PixelBits'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
               want);
    end
    error_count++;
  endtask

  // Waits until every pixel has been taken and every result has come back.
  task automatic drain();
    while (pixel_q.size() != 0 || expected_costs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_row_length(input logic [RowLenBits-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    prd_row_len = value;
    gen_len     = clamp_len(value);
    settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Input side: a transfer moves the head of the pending queue into the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      compute_seam_cost(pixel_q[0]);
      pixel_q.pop_front();
      pixels_taken++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(1, 7) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel_q[0].pixel;
        s_axis_tuser  <= pixel_q[0].frame_start;
      end
    end
  end

  // Output side ready, with random bursts and the occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    seam_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tlast) rows_closed++;
      if (expected_costs.size() == 0) begin
        report_mismatch("unexpected result, energy", m_axis_tdata[EnergyBits-1:0], -1);
      end else begin
        want = expected_costs.pop_front();
        if (m_axis_tdata[EnergyBits-1:0] !== want.energy) begin
          report_mismatch("energy", m_axis_tdata[EnergyBits-1:0], want.energy);
        end
        if (m_axis_tdata[EnergyBits +: CostBits] !== want.path_cost) begin
          report_mismatch("path_cost", m_axis_tdata[EnergyBits +: CostBits], want.path_cost);
        end
        if (m_axis_tlast !== want.row_end) begin
          report_mismatch("row_end", m_axis_tlast, want.row_end);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [PixelBits-1:0]  prev;
    logic [RowLenBits-1:0] len_value;
    int                    rand_count;
    int                    run_len;
    bit                    fs;
    prev       = '0;
    rand_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset row length, stream begun without a frame start.
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'h8001, 1'b0);
    drain();

    // Two-pixel rows; the second row gives the peak energy at its left end.
    set_row_length(RowLenBits'(2));
    queue_pixel(16'hFFFF, 1'b1);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    drain();

    // A zero length acts as one pixel per row.
    set_row_length('0);
    queue_pixel(16'h0005, 1'b0);
    queue_pixel(16'h0009, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    drain();

    // Stop three pixels into the second row, then shrink the row under it.
    set_row_length(RowLenBits'(6));
    queue_pixel(16'h1234, 1'b1);
    for (int i = 0; i < 8; i++) queue_pixel(PixelBits'($urandom), 1'b0);
    drain();
    set_row_length(RowLenBits'(3));
    for (int i = 0; i < 3; i++) queue_pixel(PixelBits'($urandom), 1'b0);
    drain();

    // Oversized length clamps to the store depth; a frame start mid-row.
    set_row_length(11'h7FF);
    queue_pixel(16'hAAAA, 1'b1);
    queue_pixel(16'h5555, 1'b0);
    queue_pixel(16'hFFFF, 1'b1);
    queue_pixel(16'h0000, 1'b0);
    drain();

    // Full-width row length, with a long output hold-off while pixels keep coming.
    set_row_length(11'd1024);
    queue_pixel(PixelBits'($urandom), 1'b1);
    for (int i = 0; i < 299; i++) begin
      prev = pick_pixel(prev);
      queue_pixel(prev, 1'b0);
    end
    hold_requests++;
    drain();

    // Random phases: mostly whole frames of short rows, some noise.
    while (rand_count < 400) begin
      case ($urandom_range(0, 19))
        0:       len_value = '0;
        1:       len_value = RowLenBits'(1);
        2:       len_value = RowLenBits'($urandom_range(1025, 2047));
        3:       len_value = RowLenBits'($urandom_range(17, 40));
        default: len_value = RowLenBits'($urandom_range(2, 12));
      endcase
      idle_on = (rand_count >= 340) ? 1'b0 : ($urandom_range(0, 3) != 0);
      set_row_length(len_value);
      run_len = $urandom_range(8, 60);
      for (int i = 0; i < run_len; i++) begin
        fs   = (i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) == 0);
        prev = pick_pixel(prev);
        queue_pixel(prev, fs);
        rand_count++;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d pixel transfers under %0d row length settings, %0d rows closed.",
             pixels_taken, settings, rows_closed);
    $display("Mismatches found: %0d.", error_count);
    if (error_count == 0 && expected_costs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/secs_pkg.sv
hdl/seam_energy_cost_stream.sv
dv/testbench.sv
